// ===== sv/pcl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PID controller with limits: widths, configuration record,
// sequencer states, control structs and wide fixed-point helpers.
// No dependencies.
package pcl_pkg;

	localparam int unsigned SAMPLE_WIDTH_DEF = 16;
	localparam int unsigned CFG_W            = 48;
	localparam int unsigned CFG_IDX_W        = 3;
	localparam int unsigned DRIVE_W          = 16;
	localparam int unsigned MUL_W            = 33;
	localparam int unsigned PROD_W           = 2 * MUL_W;
	localparam int unsigned ACC_W            = 82;
	localparam int unsigned FRAC_W           = 16;
	localparam int unsigned WFRAC_W          = 15;
	localparam int unsigned SUM_W            = 43;
	localparam int unsigned ACT_W            = 40;
	localparam int unsigned INTEG_W          = 48;
	localparam int unsigned TERM_W           = 32;

	typedef logic signed [ACC_W-1:0] wide_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P_GAIN,
		REG_I_GAIN,
		REG_D_GAIN,
		REG_SMOOTH,
		REG_OUT_LIM,
		REG_ERR_LIM,
		REG_INT_CAP,
		REG_INT_DECAY
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] p_gain;
		logic signed [31:0] i_gain;
		logic signed [31:0] d_gain;
		logic [15:0]        w_der;
		logic [15:0]        w_sp;
		logic [15:0]        w_out;
		logic signed [15:0] lo_clip;
		logic signed [15:0] hi_clip;
		logic signed [15:0] offset;
		logic [15:0]        hold_band;
		logic [15:0]        rate_lim;
		logic [15:0]        kill;
		logic signed [31:0] cap;
		logic [15:0]        dec_norm;
		logic [15:0]        dec_cap;
	} cfg_t;

	// Sequencer steps; each step issues at most one multiplication.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_FS1,
		ST_FS2,
		ST_FS3,
		ST_HOLD,
		ST_ERR,
		ST_DF1,
		ST_DF2,
		ST_DF3,
		ST_DEC2,
		ST_DEC3,
		ST_P,
		ST_I1,
		ST_I2,
		ST_D,
		ST_O1,
		ST_O2,
		ST_O3,
		ST_O4,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic fire;
		logic clear;
		logic hold;
		logic slot_free;
	} seq_in_t;

	typedef struct packed {
		state_t st;
		logic   idle;
		logic   emit;
	} seq_ctl_t;

	// Saturate a wide signed value to a signed range of the given width.
	function automatic wide_t sat_w(input wide_t v, input int unsigned bits);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// Arithmetic shift right with rounding half up.
	function automatic wide_t shr_rnd(input wide_t v, input int unsigned s);
		return (v + (wide_t'(1) <<< (s - 1))) >>> s;
	endfunction

endpackage

// ===== sv/pcl_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on pcl_pkg for operand widths.
module pcl_mul (
	input  logic                                clk,
	input  logic signed [pcl_pkg::MUL_W-1:0]    a,
	input  logic signed [pcl_pkg::MUL_W-1:0]    b,
	output logic signed [pcl_pkg::PROD_W-1:0]   prod
);

	logic signed [pcl_pkg::PROD_W-1:0] prod_q;

	// One product per cycle, registered before any further use.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== sv/pcl_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file: decodes plain writes into the settings record.
// Depends on pcl_pkg for the register indexes and the record type.
module pcl_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pcl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcl_pkg::CFG_W-1:0]        cfg_data,
	output pcl_pkg::cfg_t                    cfg
);

	pcl_pkg::cfg_t cfg_q;

	// Registers take their defaults on reset and are written one at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain    <= '0;
			cfg_q.i_gain    <= '0;
			cfg_q.d_gain    <= '0;
			cfg_q.w_der     <= 16'h8000;
			cfg_q.w_sp      <= 16'h8000;
			cfg_q.w_out     <= 16'h8000;
			cfg_q.lo_clip   <= 16'sh8000;
			cfg_q.hi_clip   <= 16'sh7FFF;
			cfg_q.offset    <= '0;
			cfg_q.hold_band <= '0;
			cfg_q.rate_lim  <= '0;
			cfg_q.kill      <= '0;
			cfg_q.cap       <= '0;
			cfg_q.dec_norm  <= 16'h8000;
			cfg_q.dec_cap   <= 16'h8000;
		end else if (cfg_we) begin
			unique case (pcl_pkg::reg_idx_t'(cfg_index))
				pcl_pkg::REG_P_GAIN: begin
					cfg_q.p_gain <= $signed(cfg_data[31:0]);
				end
				pcl_pkg::REG_I_GAIN: begin
					cfg_q.i_gain <= $signed(cfg_data[31:0]);
				end
				pcl_pkg::REG_D_GAIN: begin
					cfg_q.d_gain <= $signed(cfg_data[31:0]);
				end
				pcl_pkg::REG_SMOOTH: begin
					cfg_q.w_der <= cfg_data[15:0];
					cfg_q.w_sp  <= cfg_data[31:16];
					cfg_q.w_out <= cfg_data[47:32];
				end
				pcl_pkg::REG_OUT_LIM: begin
					cfg_q.lo_clip <= $signed(cfg_data[15:0]);
					cfg_q.hi_clip <= $signed(cfg_data[31:16]);
					cfg_q.offset  <= $signed(cfg_data[47:32]);
				end
				pcl_pkg::REG_ERR_LIM: begin
					cfg_q.hold_band <= cfg_data[15:0];
					cfg_q.rate_lim  <= cfg_data[31:16];
					cfg_q.kill      <= cfg_data[47:32];
				end
				pcl_pkg::REG_INT_CAP: begin
					cfg_q.cap <= $signed(cfg_data[31:0]);
				end
				pcl_pkg::REG_INT_DECAY: begin
					cfg_q.dec_norm <= cfg_data[15:0];
					cfg_q.dec_cap  <= cfg_data[31:16];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/pcl_seq.sv =====
`timescale 1ns / 1ps
// Step sequencer for the shared multiplier datapath.
// Depends on pcl_pkg for the state type and the control structs.
module pcl_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  pcl_pkg::seq_in_t   sin,
	output pcl_pkg::seq_ctl_t  ctl
);

	pcl_pkg::state_t state_q;
	pcl_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next step: a chain, waiting in idle and wherever a result is handed over.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pcl_pkg::ST_IDLE: begin
				if (sin.fire) begin
					state_nxt = sin.clear ? pcl_pkg::ST_CLR : pcl_pkg::ST_FS1;
				end
			end
			pcl_pkg::ST_CLR, pcl_pkg::ST_HOLD, pcl_pkg::ST_OUT: begin
				if (sin.slot_free) begin
					state_nxt = pcl_pkg::ST_IDLE;
				end
			end
			pcl_pkg::ST_FS1:  state_nxt = pcl_pkg::ST_FS2;
			pcl_pkg::ST_FS2:  state_nxt = pcl_pkg::ST_FS3;
			pcl_pkg::ST_FS3:  state_nxt = sin.hold ? pcl_pkg::ST_HOLD : pcl_pkg::ST_ERR;
			pcl_pkg::ST_ERR:  state_nxt = pcl_pkg::ST_DF1;
			pcl_pkg::ST_DF1:  state_nxt = pcl_pkg::ST_DF2;
			pcl_pkg::ST_DF2:  state_nxt = pcl_pkg::ST_DF3;
			pcl_pkg::ST_DF3:  state_nxt = pcl_pkg::ST_DEC2;
			pcl_pkg::ST_DEC2: state_nxt = pcl_pkg::ST_DEC3;
			pcl_pkg::ST_DEC3: state_nxt = pcl_pkg::ST_P;
			pcl_pkg::ST_P:    state_nxt = pcl_pkg::ST_I1;
			pcl_pkg::ST_I1:   state_nxt = pcl_pkg::ST_I2;
			pcl_pkg::ST_I2:   state_nxt = pcl_pkg::ST_D;
			pcl_pkg::ST_D:    state_nxt = pcl_pkg::ST_O1;
			pcl_pkg::ST_O1:   state_nxt = pcl_pkg::ST_O2;
			pcl_pkg::ST_O2:   state_nxt = pcl_pkg::ST_O3;
			pcl_pkg::ST_O3:   state_nxt = pcl_pkg::ST_O4;
			pcl_pkg::ST_O4:   state_nxt = pcl_pkg::ST_OUT;
			default:          state_nxt = pcl_pkg::ST_IDLE;
		endcase
	end

	// Control outputs derived from the current step.
	always_comb begin
		ctl.st   = state_q;
		ctl.idle = (state_q == pcl_pkg::ST_IDLE);
		ctl.emit = ((state_q == pcl_pkg::ST_CLR) || (state_q == pcl_pkg::ST_HOLD) ||
			(state_q == pcl_pkg::ST_OUT)) && sin.slot_free;
	end

endmodule

// ===== sv/pid_controller_with_limits.sv =====
`timescale 1ns / 1ps
// A control sample steps through FS1-FS3, ERR, DF1-DF3, DEC2, DEC3, P, I1,
// I2, D and O1-O4 to OUT, a dead-zone hold from FS3 to HOLD, a clear to CLR.
// A new transaction is taken only in idle; the pace is set by the chain of
// products through the single shared 33x33 multiplier and by output stalls.
// Reset: asynchronous, clears the sequencer, the stored terms and the output
// valid flag, and loads the configuration defaults.
module pid_controller_with_limits #(
	parameter int unsigned SAMPLE_WIDTH = pcl_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pcl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pcl_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic signed [SAMPLE_WIDTH-1:0]       measurement,
	input  logic signed [SAMPLE_WIDTH-1:0]       setpoint,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pcl_pkg::DRIVE_W-1:0]   drive,
	output logic                                 saturated,
	output logic                                 held
);

	pcl_pkg::cfg_t     cfg;
	pcl_pkg::seq_in_t  sin;
	pcl_pkg::seq_ctl_t ctl;

	logic in_fire;
	logic slot_free;

	logic signed [SAMPLE_WIDTH-1:0]          meas_q;
	logic signed [SAMPLE_WIDTH-1:0]          sp_q;
	logic signed [pcl_pkg::TERM_W-1:0]       fs_q;
	logic signed [pcl_pkg::INTEG_W-1:0]      integ_q;
	logic signed [pcl_pkg::TERM_W-1:0]       df_q;
	logic signed [pcl_pkg::DRIVE_W-1:0]      ld_q;
	logic                                    sflag_q;
	logic                                    hold_q;
	logic                                    dec_sel_q;
	pcl_pkg::wide_t                          acc_q;
	logic signed [pcl_pkg::TERM_W-1:0]       err_q;
	logic signed [pcl_pkg::TERM_W-1:0]       nf_q;
	logic signed [pcl_pkg::TERM_W-1:0]       d_q;
	logic signed [pcl_pkg::PROD_W-1:0]       t_q;
	logic signed [pcl_pkg::SUM_W-1:0]        sum_q;
	logic signed [pcl_pkg::ACT_W-1:0]        act_q;
	logic                                    out_valid_q;
	logic signed [pcl_pkg::DRIVE_W-1:0]      drive_q;
	logic                                    sat_q;
	logic                                    held_q;

	logic signed [pcl_pkg::MUL_W-1:0]        mul_a;
	logic signed [pcl_pkg::MUL_W-1:0]        mul_b;
	logic signed [pcl_pkg::PROD_W-1:0]       prod;

	pcl_pkg::wide_t prod_w;
	pcl_pkg::wide_t sp_sc;
	pcl_pkg::wide_t ms_sc;
	pcl_pkg::wide_t dz_abs;
	pcl_pkg::wide_t blend_r;
	pcl_pkg::wide_t err_raw;
	pcl_pkg::wide_t err_lim;
	pcl_pkg::wide_t rl_w;
	pcl_pkg::wide_t err_abs;
	pcl_pkg::wide_t integ_add;
	pcl_pkg::wide_t term_r;
	pcl_pkg::wide_t ti_w;
	pcl_pkg::wide_t act_d;
	pcl_pkg::wide_t out_blend;
	pcl_pkg::wide_t off_sum;
	pcl_pkg::wide_t lo_w;
	pcl_pkg::wide_t hi_w;
	pcl_pkg::wide_t clip_a;
	pcl_pkg::wide_t clip_b;
	logic [15:0]    dec_f;
	logic           sat_c;

	pcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sin    (sin),
		.ctl    (ctl)
	);

	pcl_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Handshake: a new transaction is taken whenever the sequencer is idle.
	assign in_stall  = !ctl.idle;
	assign in_fire   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		sin.fire      = in_fire;
		sin.clear     = kind;
		sin.hold      = hold_q;
		sin.slot_free = slot_free;
	end

	// Scaled samples, dead-zone distance and the shared rounding paths.
	always_comb begin
		prod_w  = pcl_pkg::wide_t'(prod);
		sp_sc   = pcl_pkg::sat_w(pcl_pkg::wide_t'(sp_q) <<< pcl_pkg::FRAC_W, 32);
		ms_sc   = pcl_pkg::sat_w(pcl_pkg::wide_t'(meas_q) <<< pcl_pkg::FRAC_W, 32);
		dz_abs  = pcl_pkg::wide_t'(meas_q) - pcl_pkg::wide_t'(sp_q);
		if (dz_abs < 0) begin
			dz_abs = -dz_abs;
		end
		blend_r = pcl_pkg::shr_rnd(acc_q + prod_w, pcl_pkg::WFRAC_W);
		term_r  = pcl_pkg::sat_w(pcl_pkg::shr_rnd(prod_w, pcl_pkg::FRAC_W), 40);
	end

	// Error with optional rate limit, integrator step with kill, decay select.
	always_comb begin
		err_raw = pcl_pkg::sat_w(pcl_pkg::wide_t'(fs_q) - ms_sc, 32);
		rl_w    = pcl_pkg::wide_t'(cfg.rate_lim) <<< pcl_pkg::FRAC_W;
		err_lim = err_raw;
		if (cfg.rate_lim != '0) begin
			if (err_lim > rl_w) begin
				err_lim = rl_w;
			end
			if (err_lim < -rl_w) begin
				err_lim = -rl_w;
			end
		end
		err_abs = pcl_pkg::wide_t'(err_q);
		if (err_abs < 0) begin
			err_abs = -err_abs;
		end
		if (err_abs < (pcl_pkg::wide_t'(cfg.kill) <<< pcl_pkg::FRAC_W)) begin
			integ_add = pcl_pkg::sat_w(pcl_pkg::wide_t'(err_q), 48);
		end else begin
			integ_add = pcl_pkg::sat_w(pcl_pkg::wide_t'(integ_q) +
				pcl_pkg::wide_t'(err_q), 48);
		end
		dec_f = dec_sel_q ? cfg.dec_cap : cfg.dec_norm;
	end

	// Term combination, output filter, offset and clip.
	always_comb begin
		ti_w      = pcl_pkg::sat_w(pcl_pkg::wide_t'(t_q) +
			pcl_pkg::shr_rnd(prod_w, pcl_pkg::FRAC_W), 40);
		act_d     = pcl_pkg::sat_w(pcl_pkg::wide_t'(sum_q) + term_r, 40);
		out_blend = pcl_pkg::sat_w(pcl_pkg::shr_rnd(acc_q + (prod_w <<< pcl_pkg::FRAC_W),
			pcl_pkg::WFRAC_W), 40);
		off_sum   = pcl_pkg::shr_rnd(pcl_pkg::wide_t'(act_q) +
			(pcl_pkg::wide_t'(cfg.offset) <<< pcl_pkg::FRAC_W), pcl_pkg::FRAC_W);
		lo_w      = pcl_pkg::wide_t'(cfg.lo_clip);
		hi_w      = pcl_pkg::wide_t'(cfg.hi_clip);
		clip_a    = (off_sum < lo_w) ? lo_w : off_sum;
		clip_b    = (clip_a > hi_w) ? hi_w : clip_a;
		sat_c     = (clip_b == lo_w) || (clip_b == hi_w);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.st)
			pcl_pkg::ST_FS1: begin
				mul_a = sp_sc[pcl_pkg::MUL_W-1:0];
				mul_b = $signed({17'b0, cfg.w_sp});
			end
			pcl_pkg::ST_FS2: begin
				mul_a = pcl_pkg::MUL_W'(fs_q);
				mul_b = 33'sd32768 - $signed({17'b0, cfg.w_sp});
			end
			pcl_pkg::ST_DF1: begin
				mul_a = pcl_pkg::MUL_W'(err_q);
				mul_b = $signed({17'b0, cfg.w_der});
			end
			pcl_pkg::ST_DF2: begin
				mul_a = pcl_pkg::MUL_W'(df_q);
				mul_b = 33'sd32768 - $signed({17'b0, cfg.w_der});
			end
			pcl_pkg::ST_DF3: begin
				mul_a = pcl_pkg::MUL_W'($signed(integ_q[47:16]));
				mul_b = $signed({17'b0, dec_f});
			end
			pcl_pkg::ST_DEC2: begin
				mul_a = $signed({17'b0, integ_q[15:0]});
				mul_b = $signed({17'b0, dec_f});
			end
			pcl_pkg::ST_DEC3: begin
				mul_a = pcl_pkg::MUL_W'(err_q);
				mul_b = pcl_pkg::MUL_W'(cfg.p_gain);
			end
			pcl_pkg::ST_P: begin
				mul_a = pcl_pkg::MUL_W'($signed(integ_q[47:16]));
				mul_b = pcl_pkg::MUL_W'(cfg.i_gain);
			end
			pcl_pkg::ST_I1: begin
				mul_a = $signed({17'b0, integ_q[15:0]});
				mul_b = pcl_pkg::MUL_W'(cfg.i_gain);
			end
			pcl_pkg::ST_I2: begin
				mul_a = pcl_pkg::MUL_W'(d_q);
				mul_b = pcl_pkg::MUL_W'(cfg.d_gain);
			end
			pcl_pkg::ST_O1: begin
				mul_a = pcl_pkg::MUL_W'($signed(act_q[39:16]));
				mul_b = $signed({17'b0, cfg.w_out});
			end
			pcl_pkg::ST_O2: begin
				mul_a = $signed({17'b0, act_q[15:0]});
				mul_b = $signed({17'b0, cfg.w_out});
			end
			pcl_pkg::ST_O3: begin
				mul_a = pcl_pkg::MUL_W'(ld_q);
				mul_b = 33'sd32768 - $signed({17'b0, cfg.w_out});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meas_q <= measurement;
			sp_q   <= setpoint;
		end
		unique case (ctl.st)
			pcl_pkg::ST_FS1: begin
				hold_q <= (dz_abs <= pcl_pkg::wide_t'(cfg.hold_band));
			end
			pcl_pkg::ST_FS2, pcl_pkg::ST_DF2: begin
				acc_q <= prod_w;
			end
			pcl_pkg::ST_ERR: begin
				err_q <= err_lim[pcl_pkg::TERM_W-1:0];
			end
			pcl_pkg::ST_DF3: begin
				nf_q <= pcl_pkg::TERM_W'(pcl_pkg::sat_w(blend_r, 32));
			end
			pcl_pkg::ST_DEC2, pcl_pkg::ST_O2: begin
				acc_q <= prod_w <<< pcl_pkg::FRAC_W;
			end
			pcl_pkg::ST_P: begin
				sum_q <= term_r[pcl_pkg::SUM_W-1:0];
			end
			pcl_pkg::ST_I1: begin
				t_q <= prod;
			end
			pcl_pkg::ST_I2: begin
				sum_q <= sum_q + ti_w[pcl_pkg::SUM_W-1:0];
			end
			pcl_pkg::ST_D: begin
				act_q <= act_d[pcl_pkg::ACT_W-1:0];
			end
			pcl_pkg::ST_O3: begin
				acc_q <= acc_q + prod_w;
			end
			pcl_pkg::ST_O4: begin
				act_q <= out_blend[pcl_pkg::ACT_W-1:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Stored terms, all reset; a clear zeroes integ_q, df_q, ld_q and sflag_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q      <= '0;
			integ_q   <= '0;
			df_q      <= '0;
			ld_q      <= '0;
			sflag_q   <= 1'b0;
			dec_sel_q <= 1'b0;
			d_q       <= '0;
		end else begin
			unique case (ctl.st)
				pcl_pkg::ST_FS3: begin
					fs_q <= pcl_pkg::TERM_W'(pcl_pkg::sat_w(blend_r, 32));
				end
				pcl_pkg::ST_DF1: begin
					integ_q <= integ_add[pcl_pkg::INTEG_W-1:0];
				end
				pcl_pkg::ST_DF2: begin
					dec_sel_q <= pcl_pkg::wide_t'(integ_q) >
						(pcl_pkg::wide_t'(cfg.cap) <<< pcl_pkg::FRAC_W);
				end
				pcl_pkg::ST_DEC2: begin
					d_q  <= pcl_pkg::TERM_W'(pcl_pkg::sat_w(pcl_pkg::wide_t'(nf_q) -
						pcl_pkg::wide_t'(df_q), 32));
					df_q <= nf_q;
				end
				pcl_pkg::ST_DEC3: begin
					integ_q <= pcl_pkg::INTEG_W'(pcl_pkg::sat_w(blend_r, 48));
				end
				pcl_pkg::ST_CLR: begin
					if (ctl.emit) begin
						integ_q <= '0;
						df_q    <= '0;
						ld_q    <= '0;
						sflag_q <= 1'b0;
					end
				end
				pcl_pkg::ST_OUT: begin
					if (ctl.emit) begin
						ld_q    <= clip_b[pcl_pkg::DRIVE_W-1:0];
						sflag_q <= sat_c;
					end
				end
				default: begin
					fs_q <= fs_q;
				end
			endcase
		end
	end

	// Output register: holds one finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			priority case (ctl.st)
				pcl_pkg::ST_HOLD: begin
					drive_q <= ld_q;
					sat_q   <= sflag_q;
					held_q  <= 1'b1;
				end
				pcl_pkg::ST_OUT: begin
					drive_q <= clip_b[pcl_pkg::DRIVE_W-1:0];
					sat_q   <= sat_c;
					held_q  <= 1'b0;
				end
				default: begin
					drive_q <= '0;
					sat_q   <= 1'b0;
					held_q  <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;
	assign held      = held_q;

	// An accepted transaction always starts the sequencer.
	a_fire_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !ctl.idle)
		else $error("sequencer stayed idle after an accepted transaction");

	// A result is only written into a free output slot.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || !out_stall))
		else $error("result written over a pending transaction");

	// A computed, saturated drive sits on one of the clip limits.
	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !held_q && sat_q) |->
		((drive_q == cfg.lo_clip) || (drive_q == cfg.hi_clip)))
		else $error("saturation flag set with drive away from the clip limits");

endmodule
